[hw/rtl/pdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types and constants of the duplicate packet filter
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int KEY_W          = 64;
    localparam int ACK_W          = 32;
    localparam int HASH_CNT_OUT_W = 8;
    localparam int ACK_CNT_OUT_W  = 7;
    localparam int DUP_W          = 32;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DUP,
        S_OLD,
        S_WRITE,
        S_REMOVE,
        S_CLEAR,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_step;
        logic rd_old;
        logic wr_record;
        logic wr_remove;
        logic count_dup;
        logic load_result;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic clr_done;
        logic out_busy;
        t_op  op;
    } t_stat;

endpackage

[hw/rtl/packet_duplicate_filter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_duplicate_filter_core
// duplicate packet filter with ring histories of payload hashes and ack codes
// ----------------------------------------------------------------------------
//
//  channel   valid        ready        payload
//  request   i_in_valid   o_in_ready   i_opcode i_is_ack i_key i_direct_route
//  result    o_out_valid  i_out_ready  o_seen o_hash_entries_used
//                                      o_ack_entries_used o_direct_duplicates
//                                      o_flood_duplicates
//
//  scan: one entry of the selected store is compared per cycle through a
//  registered read port; a record miss then reads the slot at the ring
//  pointer and writes the key there, a hit ends the scan at the match;
//  clear all sweeps both memories
//  reset: synchronous, then a clearing pass over both memories with
//  o_in_ready low; a full result register stalls only a final step
//
module packet_duplicate_filter_core #(
    parameter int HASH_DEPTH = 128,
    parameter int ACK_DEPTH  = 64,
    parameter int HASH_BYTES = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_opcode,
    input  logic                                  i_is_ack,
    input  logic [pdf_pkg::KEY_W-1:0]             i_key,
    input  logic                                  i_direct_route,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_seen,
    output logic [pdf_pkg::HASH_CNT_OUT_W-1:0]    o_hash_entries_used,
    output logic [pdf_pkg::ACK_CNT_OUT_W-1:0]     o_ack_entries_used,
    output logic [pdf_pkg::DUP_W-1:0]             o_direct_duplicates,
    output logic [pdf_pkg::DUP_W-1:0]             o_flood_duplicates
);

    // command and status between sequencer and datapath
    pdf_pkg::t_cmd  cmd;
    pdf_pkg::t_stat stat;
    pdf_pkg::t_op   opcode;

    // opcode as its enum, all four codes are meaningful
    assign opcode = pdf_pkg::t_op'(i_opcode);

    // sequencer: init sweep, scan, record, remove or clear, result hand-off
    pdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (opcode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // memories, pointers, counters and the result register
    pdf_dpath #(
        .HASH_DEPTH (HASH_DEPTH),
        .ACK_DEPTH  (ACK_DEPTH),
        .HASH_BYTES (HASH_BYTES)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_opcode            (opcode),
        .i_is_ack            (i_is_ack),
        .i_key               (i_key),
        .i_direct_route      (i_direct_route),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_seen              (o_seen),
        .o_hash_entries_used (o_hash_entries_used),
        .o_ack_entries_used  (o_ack_entries_used),
        .o_direct_duplicates (o_direct_duplicates),
        .o_flood_duplicates  (o_flood_duplicates)
    );

endmodule

[hw/rtl/pdf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_ctrl
// sequencer for lookup, record, remove and clear passes
// ----------------------------------------------------------------------------
module pdf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  pdf_pkg::t_op    i_opcode,
    input  pdf_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output pdf_pkg::t_cmd   o_cmd
);

    pdf_pkg::t_state r_state;
    pdf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdf_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pdf_pkg::S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = pdf_pkg::S_IDLE;
                end
            end
            pdf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == pdf_pkg::OP_CLEAR) begin
                        n_state = pdf_pkg::S_CLEAR;
                    end else begin
                        n_state = pdf_pkg::S_SCAN;
                    end
                end
            end
            pdf_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit || i_stat.scan_end) begin
                    case (i_stat.op)
                        pdf_pkg::OP_RECORD: begin
                            n_state = i_stat.hit ? pdf_pkg::S_DUP : pdf_pkg::S_OLD;
                        end
                        pdf_pkg::OP_REMOVE: begin
                            n_state = i_stat.hit ? pdf_pkg::S_REMOVE : pdf_pkg::S_FINISH;
                        end
                        default: begin
                            n_state = pdf_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            pdf_pkg::S_DUP: begin
                o_cmd.count_dup = 1'b1;
                n_state         = pdf_pkg::S_FINISH;
            end
            pdf_pkg::S_OLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = pdf_pkg::S_WRITE;
            end
            pdf_pkg::S_WRITE: begin
                o_cmd.wr_record = 1'b1;
                n_state         = pdf_pkg::S_FINISH;
            end
            pdf_pkg::S_REMOVE: begin
                o_cmd.wr_remove = 1'b1;
                n_state         = pdf_pkg::S_FINISH;
            end
            pdf_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = pdf_pkg::S_FINISH;
                end
            end
            pdf_pkg::S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = pdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdf_pkg::S_INIT;
            end
        endcase
    end

endmodule

[hw/rtl/pdf_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_dpath
// history memories, ring pointers, entry counts and duplicate counters
// ----------------------------------------------------------------------------
module pdf_dpath #(
    parameter int HASH_DEPTH = 128,
    parameter int ACK_DEPTH  = 64,
    parameter int HASH_BYTES = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pdf_pkg::t_cmd                         i_cmd,
    output pdf_pkg::t_stat                        o_stat,
    input  pdf_pkg::t_op                          i_opcode,
    input  logic                                  i_is_ack,
    input  logic [pdf_pkg::KEY_W-1:0]             i_key,
    input  logic                                  i_direct_route,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic                                  o_seen,
    output logic [pdf_pkg::HASH_CNT_OUT_W-1:0]    o_hash_entries_used,
    output logic [pdf_pkg::ACK_CNT_OUT_W-1:0]     o_ack_entries_used,
    output logic [pdf_pkg::DUP_W-1:0]             o_direct_duplicates,
    output logic [pdf_pkg::DUP_W-1:0]             o_flood_duplicates
);

    localparam int HW   = 8 * HASH_BYTES;
    localparam int AW   = pdf_pkg::ACK_W;
    localparam int MAXD = (HASH_DEPTH > ACK_DEPTH) ? HASH_DEPTH : ACK_DEPTH;
    localparam int IW   = $clog2(MAXD + 1);
    localparam int HAW  = $clog2(HASH_DEPTH);
    localparam int AAW  = $clog2(ACK_DEPTH);
    localparam int HCW  = $clog2(HASH_DEPTH + 1);
    localparam int ACW  = $clog2(ACK_DEPTH + 1);
    localparam int HXW  = HCW + pdf_pkg::HASH_CNT_OUT_W;
    localparam int AXW  = ACW + pdf_pkg::ACK_CNT_OUT_W;

    // captured request
    pdf_pkg::t_op              r_op;
    logic                      r_ack;
    logic [pdf_pkg::KEY_W-1:0] r_key;
    logic                      r_direct;

    // scan control
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    logic           r_found;
    logic [IW-1:0]  r_found_idx;

    // memories
    logic [HW-1:0]  r_hash_mem [HASH_DEPTH];
    logic [AW-1:0]  r_ack_mem  [ACK_DEPTH];
    logic [HW-1:0]  r_h_rdata;
    logic [AW-1:0]  r_a_rdata;

    logic [HAW-1:0] r_hptr;
    logic [AAW-1:0] r_aptr;
    logic [HCW-1:0] r_hcnt;
    logic [ACW-1:0] r_acnt;
    logic [pdf_pkg::DUP_W-1:0] r_direct_dup;
    logic [pdf_pkg::DUP_W-1:0] r_flood_dup;

    logic r_out_valid;

    logic [HW-1:0]  key_h;
    logic [AW-1:0]  key_a;
    logic           key_nz;
    logic           old_nz;
    logic           hit;
    logic           scan_end;
    logic           idx_in_range;
    logic           h_we;
    logic [HAW-1:0] h_waddr;
    logic [HW-1:0]  h_wdata;
    logic [HAW-1:0] h_raddr;
    logic           a_we;
    logic [AAW-1:0] a_waddr;
    logic [AW-1:0]  a_wdata;
    logic [AAW-1:0] a_raddr;
    logic [HXW-1:0] hcnt_ext;
    logic [AXW-1:0] acnt_ext;

    assign key_h  = r_key[HW-1:0];
    assign key_a  = r_key[AW-1:0];
    assign key_nz = r_ack ? (key_a != '0) : (key_h != '0);
    assign old_nz = r_ack ? (r_a_rdata != '0) : (r_h_rdata != '0);

    assign idx_in_range = r_ack ? (r_idx < IW'(ACK_DEPTH)) : (r_idx < IW'(HASH_DEPTH));
    assign hit = r_rd_vld && (r_ack ? (r_a_rdata == key_a) : (r_h_rdata == key_h));
    assign scan_end = r_rd_vld && (r_ack ? (r_rd_idx == IW'(ACK_DEPTH - 1))
                                         : (r_rd_idx == IW'(HASH_DEPTH - 1)));

    assign o_stat.hit      = hit;
    assign o_stat.scan_end = scan_end;
    assign o_stat.clr_done = (r_idx == IW'(MAXD - 1));
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_stat.op       = r_op;

    // memory port selection
    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_idx[HAW-1:0];
        h_wdata = '0;
        a_we    = 1'b0;
        a_waddr = r_idx[AAW-1:0];
        a_wdata = '0;
        if (i_cmd.clr_step) begin
            h_we = (r_idx < IW'(HASH_DEPTH));
            a_we = (r_idx < IW'(ACK_DEPTH));
        end else if (i_cmd.wr_record) begin
            h_we    = !r_ack;
            h_waddr = r_hptr;
            h_wdata = key_h;
            a_we    = r_ack;
            a_waddr = r_aptr;
            a_wdata = key_a;
        end else if (i_cmd.wr_remove) begin
            h_we    = !r_ack;
            h_waddr = r_found_idx[HAW-1:0];
            a_we    = r_ack;
            a_waddr = r_found_idx[AAW-1:0];
        end
        h_raddr = i_cmd.rd_old ? r_hptr : r_idx[HAW-1:0];
        a_raddr = i_cmd.rd_old ? r_aptr : r_idx[AAW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hash_mem[h_waddr] <= h_wdata;
        end
        r_h_rdata <= r_hash_mem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_ack_mem[a_waddr] <= a_wdata;
        end
        r_a_rdata <= r_ack_mem[a_raddr];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_key;
            r_direct <= i_direct_route;
        end
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.scan_step && hit) begin
            r_found_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op         <= pdf_pkg::OP_RECORD;
            r_ack        <= 1'b0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_hptr       <= '0;
            r_aptr       <= '0;
            r_hcnt       <= '0;
            r_acnt       <= '0;
            r_direct_dup <= '0;
            r_flood_dup  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op     <= i_opcode;
                r_ack    <= i_is_ack;
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_idx        <= r_idx + IW'(1);
                r_hptr       <= '0;
                r_aptr       <= '0;
                r_hcnt       <= '0;
                r_acnt       <= '0;
                r_direct_dup <= '0;
                r_flood_dup  <= '0;
            end
            if (i_cmd.scan_step) begin
                r_rd_vld <= idx_in_range;
                if (idx_in_range) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.rd_old) begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.count_dup) begin
                if (r_direct) begin
                    r_direct_dup <= r_direct_dup + pdf_pkg::DUP_W'(1);
                end else begin
                    r_flood_dup <= r_flood_dup + pdf_pkg::DUP_W'(1);
                end
            end
            // slot at the pointer is overwritten: count follows both old and new values
            if (i_cmd.wr_record) begin
                if (r_ack) begin
                    r_acnt <= r_acnt + ACW'(key_nz) - ACW'(old_nz);
                    r_aptr <= (r_aptr == AAW'(ACK_DEPTH - 1)) ? '0 : r_aptr + AAW'(1);
                end else begin
                    r_hcnt <= r_hcnt + HCW'(key_nz) - HCW'(old_nz);
                    r_hptr <= (r_hptr == HAW'(HASH_DEPTH - 1)) ? '0 : r_hptr + HAW'(1);
                end
            end
            // a zero key removes an already empty slot
            if (i_cmd.wr_remove) begin
                if (r_ack) begin
                    r_acnt <= r_acnt - ACW'(key_nz);
                end else begin
                    r_hcnt <= r_hcnt - HCW'(key_nz);
                end
            end
        end
    end

    // result register
    assign hcnt_ext = HXW'(r_hcnt);
    assign acnt_ext = AXW'(r_acnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_seen              <= r_found;
            o_hash_entries_used <= hcnt_ext[pdf_pkg::HASH_CNT_OUT_W-1:0];
            o_ack_entries_used  <= acnt_ext[pdf_pkg::ACK_CNT_OUT_W-1:0];
            o_direct_duplicates <= r_direct_dup;
            o_flood_duplicates  <= r_flood_dup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCW'(HASH_DEPTH))
        else $error("hash entry count above depth");
    a_acnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acnt <= ACW'(ACK_DEPTH))
        else $error("ack entry count above depth");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hptr <= HAW'(HASH_DEPTH - 1)) && (r_aptr <= AAW'(ACK_DEPTH - 1)))
        else $error("ring pointer out of range");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_result |-> !(r_out_valid && !i_out_ready))
        else $error("pending result overwritten");
    a_found_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && hit) |=> r_found)
        else $error("hit not latched");
`endif

endmodule
